>>> hw/rtl/lfucd_pkg.sv
// Package for the LFU cache directory: sizes, field widths, request codes
// and the sequencer state type. No dependencies.
`default_nettype none

package lfucd_pkg;

    // Directory geometry
    localparam int ENTRIES    = 128;
    localparam int KEY_BITS   = 64;
    localparam int COUNT_BITS = 16;

    // Field widths fixed by the port format
    localparam int LEN_BITS   = 32;
    localparam int SLOT_BITS  = 7;
    localparam int ACT_BITS   = 8;
    localparam int KEY_PORT   = 64;

    // Derived widths
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WORD_W = KEY_BITS + COUNT_BITS + LEN_BITS;
    localparam int SPAN_W = (IDX_W + 1 > ACT_BITS) ? IDX_W + 1 : ACT_BITS;

    // Request kinds
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Low slot-number bits reported on the result port
    function automatic logic [SLOT_BITS-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lfucd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module lfucd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/lfu_cache_directory_core.sv
// LFU cache directory top level: sequencer, slot-scan compare unit, valid bits.
// Depends on lfucd_pkg and lfucd_ram (key, use count and length per slot).
// A lookup ends at the first matching slot and an insert at the first empty slot;
// a miss, or an insert with all N active slots full, scans all N active slots.
// A new request is taken only after the last has finished; one RAM slot read per cycle.
// Reset: valid bits cleared at once, active_entries = 128, no clearing pass.
`default_nettype none

module lfu_cache_directory_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: active_entries
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // key[63:0], file_length[95:64]
    input  wire logic        s_axis_tuser,   // req_type
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // slot_index[6:0], stored_length[38:7], zero
    output logic [1:0]       m_axis_tuser    // hit[0], evicted[1]
);

    localparam int IDX_W  = lfucd_pkg::IDX_W;
    localparam int KB     = lfucd_pkg::KEY_BITS;
    localparam int CB     = lfucd_pkg::COUNT_BITS;
    localparam int LB     = lfucd_pkg::LEN_BITS;
    localparam int SPAN_W = lfucd_pkg::SPAN_W;

    localparam logic [CB-1:0]     CNT_MAX = {CB{1'b1}};
    localparam logic [CB-1:0]     CNT_ONE = CB'(1);
    localparam logic [SPAN_W-1:0] SPAN_N  = SPAN_W'(lfucd_pkg::ENTRIES);

    lfucd_pkg::t_state r_state, n_state;

    logic [7:0]        r_active;
    logic              r_valid [lfucd_pkg::ENTRIES];
    logic              r_req;
    logic [KB-1:0]     r_key;
    logic [LB-1:0]     r_len;
    logic [IDX_W-1:0]  r_last;
    logic [IDX_W-1:0]  r_idx;
    logic              r_issue_end;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [CB-1:0]     r_best;
    logic [IDX_W-1:0]  r_target;

    logic                          r_out_vld;
    logic                          r_out_hit;
    logic                          r_out_ev;
    logic [lfucd_pkg::SLOT_BITS-1:0] r_out_slot;
    logic [LB-1:0]                 r_out_len;

    logic [lfucd_pkg::WORD_W-1:0]  rd_word;
    logic [lfucd_pkg::WORD_W-1:0]  wr_word;
    logic [IDX_W-1:0]              wr_addr;
    logic                          wr_en;

    logic [KB-1:0]     rd_key;
    logic [CB-1:0]     rd_cnt;
    logic [LB-1:0]     rd_len;
    logic              cur_valid;
    logic              is_last;
    logic              match;
    logic              empty;
    logic              better;
    logic [IDX_W-1:0]  sel_tgt;
    logic [CB-1:0]     cnt_inc;
    logic              finish;
    logic              accept;
    logic [SPAN_W-1:0] act_ext;
    logic [IDX_W-1:0]  last_calc;

    lfucd_ram #(
        .WIDTH (lfucd_pkg::WORD_W),
        .DEPTH (lfucd_pkg::ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_word),
        .i_raddr (r_idx),
        .o_rdata (rd_word)
    );

    // Unpack the slot word read last cycle
    assign rd_len = rd_word[LB-1:0];
    assign rd_cnt = rd_word[LB+CB-1:LB];
    assign rd_key = rd_word[lfucd_pkg::WORD_W-1:LB+CB];

    // Handshake
    assign s_axis_tready = (r_state == lfucd_pkg::ST_IDLE) && (!r_out_vld || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_len, r_out_slot};
    assign m_axis_tuser  = {r_out_ev, r_out_hit};

    // Clamp the active slot count to 1..ENTRIES, kept as a last index
    always_comb begin
        act_ext = SPAN_W'(r_active);
        if (r_active == 8'd0) begin
            last_calc = '0;
        end else if (act_ext > SPAN_N) begin
            last_calc = IDX_W'(lfucd_pkg::ENTRIES - 1);
        end else begin
            last_calc = IDX_W'(act_ext - SPAN_W'(1));
        end
    end

    // Compare unit: one slot per cycle against the request
    always_comb begin
        cur_valid = r_valid[r_cmp_idx];
        is_last   = (r_cmp_idx == r_last);
        match     = cur_valid && (rd_key == r_key);
        empty     = !cur_valid;
        better    = (r_cmp_idx == '0) || (rd_cnt < r_best);
        cnt_inc   = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ONE;
        if (empty || better) begin
            sel_tgt = r_cmp_idx;
        end else begin
            sel_tgt = r_target;
        end
        finish = 1'b0;
        if (r_state == lfucd_pkg::ST_SCAN && r_cmp_vld) begin
            if (r_req == lfucd_pkg::REQ_LOOKUP) begin
                finish = match || is_last;
            end else begin
                finish = empty || is_last;
            end
        end
    end

    // Write-back on completion: count bump on a hit, new entry on an insert
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sel_tgt;
        wr_word = {r_key, CNT_ONE, r_len};
        if (finish) begin
            if (r_req == lfucd_pkg::REQ_LOOKUP) begin
                wr_en   = match;
                wr_addr = r_cmp_idx;
                wr_word = {rd_key, cnt_inc, rd_len};
            end else begin
                wr_en = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lfucd_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lfucd_pkg::ST_SCAN;
                end
            end
            lfucd_pkg::ST_SCAN: begin
                if (finish) begin
                    n_state = lfucd_pkg::ST_IDLE;
                end
            end
            default: n_state = lfucd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfucd_pkg::ST_IDLE;
            r_active    <= 8'd128;
            r_cmp_vld   <= 1'b0;
            r_issue_end <= 1'b0;
            r_idx       <= '0;
            r_out_vld   <= 1'b0;
            for (int i = 0; i < lfucd_pkg::ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;

            // Configuration write
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end

            // Drop the result once transferred
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            if (accept) begin
                r_idx       <= '0;
                r_issue_end <= 1'b0;
                r_cmp_vld   <= 1'b0;
            end else if (r_state == lfucd_pkg::ST_SCAN) begin
                // Advance the read address until the last active slot
                r_cmp_vld <= !r_issue_end && !finish;
                if (r_idx == r_last) begin
                    r_issue_end <= 1'b1;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end

            // Mark the written slot occupied
            if (finish && r_req == lfucd_pkg::REQ_INSERT) begin
                r_valid[sel_tgt] <= 1'b1;
            end

            if (finish) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    // Request payload, scan bookkeeping and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= s_axis_tuser;
            r_key  <= s_axis_tdata[KB-1:0];
            r_len  <= s_axis_tdata[lfucd_pkg::KEY_PORT+LB-1:lfucd_pkg::KEY_PORT];
            r_last <= last_calc;
        end
        if (r_state == lfucd_pkg::ST_SCAN) begin
            r_cmp_idx <= r_idx;
        end
        // Track the least-used slot seen so far
        if (r_state == lfucd_pkg::ST_SCAN && r_cmp_vld && !empty && better) begin
            r_best   <= rd_cnt;
            r_target <= r_cmp_idx;
        end
        if (finish) begin
            if (r_req == lfucd_pkg::REQ_LOOKUP) begin
                r_out_hit  <= match;
                r_out_ev   <= 1'b0;
                r_out_slot <= match ? lfucd_pkg::slot_of(r_cmp_idx) : '0;
                r_out_len  <= match ? rd_len : '0;
            end else begin
                r_out_hit  <= 1'b0;
                r_out_ev   <= !empty;
                r_out_slot <= lfucd_pkg::slot_of(sel_tgt);
                r_out_len  <= r_len;
            end
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking bench for lfu_cache_directory_core: directed and random lookups and
// inserts, with random source and sink stalls and a long sink hold-off.
// Depends on lfucd_pkg and the directory RTL; the expected results come from a local LFU model.
`timescale 1ns / 100ps

module tb_top;

    localparam int ENTRIES    = lfucd_pkg::ENTRIES;
    localparam int KEY_BITS   = lfucd_pkg::KEY_BITS;
    localparam int COUNT_BITS = lfucd_pkg::COUNT_BITS;
    localparam int LEN_BITS   = lfucd_pkg::LEN_BITS;
    localparam int SLOT_BITS  = lfucd_pkg::SLOT_BITS;
    localparam int ACT_BITS   = lfucd_pkg::ACT_BITS;
    localparam int KEY_PORT   = lfucd_pkg::KEY_PORT;

    localparam int POOL_SIZE    = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int END_SETTLE   = ENTRIES + 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int HIT_REPEATS  = 8;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
        logic [LEN_BITS-1:0]  length;
        logic                 evicted;
    } t_dir_result;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;   // key[63:0], file_length[95:64]
    logic        s_axis_tuser = 1'b0; // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // slot_index[6:0], stored_length[38:7], zero
    logic [1:0]  m_axis_tuser;        // hit[0], evicted[1]

    // Directory model state
    logic [ACT_BITS-1:0]   mdl_active;
    logic                  mdl_valid [ENTRIES];
    logic [KEY_BITS-1:0]   mdl_key   [ENTRIES];
    logic [COUNT_BITS-1:0] mdl_count [ENTRIES];
    logic [LEN_BITS-1:0]   mdl_len   [ENTRIES];

    t_dir_result pending_results[$];
    logic [KEY_PORT-1:0] key_pool [POOL_SIZE];

    bit idle_on = 1'b1;
    bit rst_done = 1'b0;
    bit hold_request = 1'b0;
    bit hold_active = 1'b0;

    int n_errors = 0;
    int n_results = 0;
    int n_lookups = 0;
    int n_hits = 0;
    int n_inserts = 0;
    int n_evicts = 0;
    int n_cfg = 0;

    lfu_cache_directory_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Compute the outcome of one request and update the directory model
    function automatic t_dir_result predict_access(input logic req,
                                                   input logic [KEY_PORT-1:0] key_in,
                                                   input logic [LEN_BITS-1:0] len_in);
        t_dir_result r;
        int n;
        int target;
        bit found_empty;
        logic [COUNT_BITS-1:0] least;
        logic [KEY_BITS-1:0] k;
        k = key_in[KEY_BITS-1:0];
        r = '0;
        n = (mdl_active == 0) ? 1 : ((mdl_active > ENTRIES) ? ENTRIES : int'(mdl_active));
        if (req == lfucd_pkg::REQ_LOOKUP) begin
            for (int i = 0; i < n; i++) begin
                if (mdl_valid[i] && mdl_key[i] == k) begin
                    // saturate the use count
                    if (mdl_count[i] != '1)
                        mdl_count[i] = mdl_count[i] + 1'b1;
                    r.hit = 1'b1;
                    r.slot = SLOT_BITS'(i);
                    r.length = mdl_len[i];
                    break;
                end
            end
        end else begin
            target = 0;
            found_empty = 1'b0;
            least = mdl_count[0];
            // first empty slot wins, else least count with lowest index
            for (int i = 0; i < n; i++) begin
                if (!mdl_valid[i]) begin
                    target = i;
                    found_empty = 1'b1;
                    break;
                end
                if (mdl_count[i] < least) begin
                    least = mdl_count[i];
                    target = i;
                end
            end
            mdl_valid[target] = 1'b1;
            mdl_key[target] = k;
            mdl_count[target] = COUNT_BITS'(1);
            mdl_len[target] = len_in;
            r.slot = SLOT_BITS'(target);
            r.length = len_in;
            r.evicted = !found_empty;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 what, n_results, got, want);
    endtask

    // Offer one request after a random gap and hold it until the transfer
    task automatic send_request(input logic req, input logic [KEY_PORT-1:0] key,
                                input logic [LEN_BITS-1:0] len, output t_dir_result pred);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {len, key};
        s_axis_tuser = req;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_access(req, key, len);
        pending_results.push_back(pred);
        if (req == lfucd_pkg::REQ_LOOKUP) begin
            n_lookups++;
            if (pred.hit)
                n_hits++;
        end else begin
            n_inserts++;
            if (pred.evicted)
                n_evicts++;
        end
    endtask

    // Write active_entries once every pending result has come back
    task automatic write_active(input logic [7:0] value);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        mdl_active = value;
        n_cfg++;
    endtask

    // Result sink: random stalls, honors the long hold-off, checks each transfer
    initial begin : result_sink
        t_dir_result want;
        int stall;
        wait (rst_done);
        forever begin
            stall = idle_on ? $urandom_range(0, 16) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            while (hold_active) begin
                m_axis_tready = 1'b0;
                @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            n_results++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", {m_axis_tuser, m_axis_tdata}, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0] !== want.hit)
                    report_mismatch("hit", m_axis_tuser[0], want.hit);
                if (m_axis_tuser[1] !== want.evicted)
                    report_mismatch("evicted", m_axis_tuser[1], want.evicted);
                if (m_axis_tdata[6:0] !== want.slot)
                    report_mismatch("slot_index", m_axis_tdata[6:0], want.slot);
                if (m_axis_tdata[38:7] !== want.length)
                    report_mismatch("stored_length", m_axis_tdata[38:7], want.length);
            end
        end
    end

    // Long sink hold-off, counted here while the source keeps offering
    initial begin : hold_off_ctl
        forever begin
            wait (hold_request);
            @(posedge i_clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active = 1'b0;
            hold_request = 1'b0;
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", quiet);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Lookups into the empty directory
    task automatic test_empty_lookup();
        t_dir_result r;
        send_request(lfucd_pkg::REQ_LOOKUP, 64'h0, 32'h0, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, r);
    endtask

    // Extreme keys and lengths, misses and a duplicate insert
    task automatic test_insert_extremes();
        t_dir_result r;
        send_request(lfucd_pkg::REQ_INSERT, 64'h0, 32'h0, r);
        send_request(lfucd_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'h0, 32'h0, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'h8000_0000_0000_0001, 32'h0, r);
        // duplicate key: the lowest matching slot must answer
        send_request(lfucd_pkg::REQ_INSERT, 64'h0, 32'h5A5A_A5A5, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'h0, 32'h0, r);
    endtask

    // Active count of one, zero, above the slot count, and least-count eviction
    task automatic test_active_limits();
        t_dir_result r;
        write_active(8'd1);
        send_request(lfucd_pkg::REQ_INSERT, 64'h1111_0000_0000_0001, 32'h0000_1001, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, r);
        write_active(8'd0);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'h1111_0000_0000_0001, 32'h0, r);
        send_request(lfucd_pkg::REQ_INSERT, 64'h2222_0000_0000_0002, 32'h0000_2002, r);
        write_active(8'd255);
        // hidden slots kept their contents
        send_request(lfucd_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, r);
        send_request(lfucd_pkg::REQ_INSERT, 64'h3333_0000_0000_0003, 32'h0000_3003, r);
        write_active(8'd2);
        send_request(lfucd_pkg::REQ_INSERT, 64'h4444_0000_0000_0004, 32'h0000_4004, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'h4444_0000_0000_0004, 32'h0, r);
        // lower count: slot 0 is replaced
        send_request(lfucd_pkg::REQ_INSERT, 64'h5555_0000_0000_0005, 32'h0000_5005, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'h5555_0000_0000_0005, 32'h0, r);
    endtask

    // Raise one slot's use count with repeated hits, then evict next to it
    task automatic test_count_order();
        t_dir_result r;
        write_active(8'd2);
        idle_on = 1'b0;
        for (int i = 0; i < HIT_REPEATS; i++)
            send_request(lfucd_pkg::REQ_LOOKUP, 64'h5555_0000_0000_0005, 32'h0, r);
        // the less used slot is the one replaced
        send_request(lfucd_pkg::REQ_INSERT, 64'h6666_0000_0000_0006, 32'h0000_6006, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'h5555_0000_0000_0005, 32'h0, r);
        send_request(lfucd_pkg::REQ_LOOKUP, 64'h6666_0000_0000_0006, 32'h0, r);
        idle_on = 1'b1;
    endtask

    // Sink holds off for a long stretch while the source keeps pushing
    task automatic test_backpressure();
        t_dir_result r;
        write_active(8'd4);
        idle_on = 1'b0;
        @(negedge i_clk);
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            send_request(i[0] ? lfucd_pkg::REQ_INSERT : lfucd_pkg::REQ_LOOKUP,
                         key_pool[i % 6], $urandom, r);
        idle_on = 1'b1;
    endtask

    // Phases of random traffic, mostly lookup-then-insert-on-miss
    task automatic test_random_traffic();
        t_dir_result r;
        logic [7:0] settings [15];
        logic [KEY_PORT-1:0] k;
        int eff;
        int psize;
        int sent;
        int pick;
        settings = '{8'd3, 8'd1, 8'd8, 8'd128, 8'd2, 8'd16, 8'd0, 8'd255,
                     8'd5, 8'd40, 8'd127, 8'd4, 8'd64, 8'd1, 8'd10};
        foreach (settings[p]) begin
            write_active(settings[p]);
            eff = (settings[p] == 0) ? 1 : ((settings[p] > ENTRIES) ? ENTRIES : settings[p]);
            psize = (eff * 2 + 2 > POOL_SIZE) ? POOL_SIZE : eff * 2 + 2;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    k = key_pool[$urandom_range(0, psize - 1)];
                    send_request(lfucd_pkg::REQ_LOOKUP, k, $urandom, r);
                    sent++;
                    if (!r.hit) begin
                        send_request(lfucd_pkg::REQ_INSERT, k, $urandom, r);
                        sent++;
                    end
                end else if (pick == 7) begin
                    send_request(lfucd_pkg::REQ_INSERT, {$urandom, $urandom}, $urandom, r);
                    sent++;
                end else if (pick == 8) begin
                    send_request(lfucd_pkg::REQ_LOOKUP, {$urandom, $urandom}, $urandom, r);
                    sent++;
                end else begin
                    // possibly a duplicate of a key already held
                    send_request(lfucd_pkg::REQ_INSERT,
                                 key_pool[$urandom_range(0, psize - 1)], $urandom, r);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence
    initial begin : main_seq
        mdl_active = ACT_BITS'(128);
        for (int i = 0; i < ENTRIES; i++) begin
            mdl_valid[i] = 1'b0;
            mdl_key[i] = '0;
            mdl_count[i] = '0;
            mdl_len[i] = '0;
        end
        key_pool[0] = 64'h0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        // Reset
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        rst_done = 1'b1;

        test_empty_lookup();
        test_insert_extremes();
        test_active_limits();
        test_count_order();
        test_backpressure();
        test_random_traffic();
        write_active(8'd128);

        // Drain and settle
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);

        $display("covered %0d lookups (%0d hits) and %0d inserts (%0d evictions)",
                 n_lookups, n_hits, n_inserts, n_evicts);
        $display("over %0d active-entry writes, %0d results checked, %0d mismatches",
                 n_cfg, n_results, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/lfucd_pkg.sv
hw/rtl/lfucd_ram.sv
hw/rtl/lfu_cache_directory_core.sv
sim/tb_top.sv
